>>> rtl/core/edist_pkg.sv
// ----------------------------------------------------------------------------
// edist_pkg
// Shared types, widths and fixed-point constants of the equirectangular
// distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package edist_pkg;

   // Field widths of the ports.
   localparam int LAT_W    = 31;
   localparam int LON_W    = 32;
   localparam int RADIUS_W = 23;
   localparam int DIST_W   = 36;

   // Internal widths.
   localparam int RAD_W  = 31;   // angle in radians, signed Q3.28
   localparam int CS_W   = 34;   // CORDIC x and y, Q1.30 with headroom
   localparam int ZW     = 33;   // CORDIC residual angle, Q2.30
   localparam int COS_W  = 32;   // cosine, signed Q1.30
   localparam int DIFF_W = 32;   // coordinate differences, Q3.28
   localparam int SQ_W   = 64;   // sum of squares
   localparam int ROOT_W = 32;   // square root of the sum of squares

   // Angle conversion: rad = round(v * pi_q30 / 7.2e9). The ratio is reduced
   // to v * 1686629713 / 3.6e9, and 3.6e9 = 1024 * 3515625.
   localparam logic [30:0] RAD_SCALE       = 31'd1686629713;
   localparam logic [31:0] RAD_HALF_NARROW = 32'd1800000000;
   localparam logic [31:0] RAD_HALF_WIDE   = 32'd3600000000;
   localparam logic [21:0] RAD_DIVISOR     = 22'd3515625;
   localparam logic [22:0] RAD_DIVISOR_X2  = 23'd7031250;
   // floor(2^54 / 3515625), used for the quotient estimate.
   localparam logic [32:0] RAD_RECIP       = 33'd5124095576;

   // Angle reduction and CORDIC constants.
   localparam logic [29:0] PI_Q28      = 30'd843314857;
   localparam logic [29:0] HALF_PI_Q28 = 30'd421657428;
   localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CS_W-1:0] ONE_Q30     = 34'sd1073741824;

   // Output scaling.
   localparam logic [DIST_W-1:0]   DIST_MAX     = 36'd45000000000;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6372797;

   // round(atan(2^-i) * 2^30) for the first steps; later steps use 2^(30-i).
   localparam logic [29:0] ATAN_Q30 [11] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
      30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
      30'd4194283,   30'd2097149,   30'd1048576
   };

   // Pipeline control that a stage group receives from the top level.
   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

   // Rotation angle of one CORDIC step.
   function automatic logic signed [ZW-1:0] cordic_angle(input int step);
      logic signed [ZW-1:0] a;
      a = '0;
      if (step <= 10) begin
         a = $signed({3'b000, ATAN_Q30[step[3:0]]});
      end else if (step <= 30) begin
         a = 33'sd1 <<< (30 - step);
      end
      return a;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/edist_to_rad.sv
// ----------------------------------------------------------------------------
// edist_to_rad
// Five-stage conversion of an angle in 1e-7 degree to radians in Q3.28,
// rounded half away from zero. Division by a constant via a reciprocal
// estimate and a two-step remainder correction.
// ----------------------------------------------------------------------------
`default_nettype none

module edist_to_rad (
   input  logic                                clock,
   input  logic                                reset,
   input  edist_pkg::pipe_ctl_type             ctl_in,
   input  logic                                wide,
   input  logic signed [31:0]                  value,
   output logic                                out_valid,
   output logic signed [edist_pkg::RAD_W-1:0] rad
);
   import edist_pkg::*;

   logic        v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic        neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [31:0] mag1_ff;
   logic [31:0] mag1_in;
   logic [62:0] scaled;
   logic [62:0] biased;
   logic [51:0] t2_ff, t2_in;
   logic [51:0] t3_ff;
   logic [62:0] est_prod;
   logic [30:0] est3_ff, est3_in;
   logic [30:0] est4_ff;
   logic [52:0] pd_full;
   logic [25:0] pd4_ff;
   logic [25:0] t4_ff;
   logic [25:0] remain;
   logic [30:0] q;
   logic signed [RAD_W-1:0] rad5_ff, rad5_in;

   // Valid bits move with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (ctl_in.advance) begin
         v1_ff <= ctl_in.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Stage one: magnitude and sign.
   assign mag1_in = value[31] ? (~value + 32'd1) : value;

   // Stage two: scale, add the rounding half and drop the power of two.
   always_comb begin
      scaled = 63'(mag1_ff) * 63'(RAD_SCALE);
      biased = scaled + 63'(wide ? RAD_HALF_WIDE : RAD_HALF_NARROW);
      t2_in  = wide ? 52'(biased >> 11) : 52'(biased >> 10);
   end

   // Stage three: quotient estimate, at most two below the true quotient.
   always_comb begin
      est_prod = 63'(t2_ff[51:22]) * 63'(RAD_RECIP);
      est3_in  = est_prod[62:32];
   end

   // Stage four: product of the estimate and the divisor.
   assign pd_full = 53'(est3_ff) * 53'(RAD_DIVISOR);

   // Stage five: remainder correction and sign.
   always_comb begin
      remain  = t4_ff - pd4_ff;
      q       = est4_ff + 31'(remain >= 26'(RAD_DIVISOR))
                        + 31'(remain >= 26'(RAD_DIVISOR_X2));
      rad5_in = neg4_ff ? $signed(~q + 31'd1) : $signed(q);
   end

   always_ff @(posedge clock) begin
      if (ctl_in.advance) begin
         mag1_ff <= mag1_in;
         neg1_ff <= value[31];
         t2_ff   <= t2_in;
         neg2_ff <= neg1_ff;
         est3_ff <= est3_in;
         t3_ff   <= t2_ff;
         neg3_ff <= neg2_ff;
         pd4_ff  <= pd_full[25:0];
         t4_ff   <= t3_ff[25:0];
         est4_ff <= est3_ff;
         neg4_ff <= neg3_ff;
         rad5_ff <= rad5_in;
      end
   end

   assign out_valid = v5_ff;
   assign rad       = rad5_ff;

endmodule

`default_nettype wire

>>> rtl/core/edist_cordic.sv
// ----------------------------------------------------------------------------
// edist_cordic
// Rotation-mode CORDIC, one register stage per step, producing the scaled
// cosine of the residual angle. A side word travels along with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module edist_cordic #(
   parameter int STEPS  = 30,
   parameter int SIDE_W = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  edist_pkg::pipe_ctl_type             ctl_in,
   input  logic signed [edist_pkg::ZW-1:0]     z_in,
   input  logic                                neg_in,
   input  logic [SIDE_W-1:0]                   side_in,
   output logic                                out_valid,
   output logic signed [edist_pkg::CS_W-1:0]   x_out,
   output logic                                neg_out,
   output logic [SIDE_W-1:0]                   side_out
);
   import edist_pkg::*;

   logic                   v_ff    [STEPS];
   logic signed [CS_W-1:0] x_ff    [STEPS];
   logic signed [CS_W-1:0] y_ff    [STEPS];
   logic signed [ZW-1:0]   z_ff    [STEPS];
   logic                   neg_ff  [STEPS];
   logic [SIDE_W-1:0]      side_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [ZW-1:0] ANGLE = cordic_angle(i);

      logic                   v_prev;
      logic signed [CS_W-1:0] x_prev, y_prev, x_in, y_in, xs, ys;
      logic signed [ZW-1:0]   z_prev, z_in_step;
      logic                   neg_prev;
      logic [SIDE_W-1:0]      side_prev;

      if (i == 0) begin : g_first
         assign v_prev    = ctl_in.valid;
         assign x_prev    = CORDIC_GAIN;
         assign y_prev    = '0;
         assign z_prev    = z_in;
         assign neg_prev  = neg_in;
         assign side_prev = side_in;
      end else begin : g_next
         assign v_prev    = v_ff[i-1];
         assign x_prev    = x_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign z_prev    = z_ff[i-1];
         assign neg_prev  = neg_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      // One micro-rotation toward zero residual angle.
      always_comb begin
         xs = x_prev >>> i;
         ys = y_prev >>> i;
         if (!z_prev[ZW-1]) begin
            x_in      = x_prev - ys;
            y_in      = y_prev + xs;
            z_in_step = z_prev - ANGLE;
         end else begin
            x_in      = x_prev + ys;
            y_in      = y_prev - xs;
            z_in_step = z_prev + ANGLE;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (ctl_in.advance) begin
            v_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl_in.advance) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in_step;
            neg_ff[i]  <= neg_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign x_out     = x_ff[STEPS-1];
   assign neg_out   = neg_ff[STEPS-1];
   assign side_out  = side_ff[STEPS-1];

endmodule

`default_nettype wire

>>> rtl/core/edist_isqrt.sv
// ----------------------------------------------------------------------------
// edist_isqrt
// Pipelined integer square root, one result bit per stage, followed by a
// stage that rounds to the nearest integer.
// ----------------------------------------------------------------------------
`default_nettype none

module edist_isqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  edist_pkg::pipe_ctl_type            ctl_in,
   input  logic [edist_pkg::SQ_W-1:0]         radicand,
   output logic                               out_valid,
   output logic [edist_pkg::ROOT_W-1:0]       root
);
   import edist_pkg::*;

   logic              v_ff    [ROOT_W];
   logic [SQ_W-1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic              vr_ff;
   logic [ROOT_W-1:0] rnd_ff, rnd_in;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
      localparam int K = ROOT_W - 1 - i;

      logic              v_prev;
      logic [SQ_W-1:0]   rem_prev, rem_in;
      logic [ROOT_W-1:0] root_prev, root_in;
      logic [SQ_W+1:0]   trial;

      if (i == 0) begin : g_first
         assign v_prev    = ctl_in.valid;
         assign rem_prev  = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign v_prev    = v_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
      end

      // Try to set result bit K: subtract (2R + 2^K) * 2^K if it fits.
      always_comb begin
         trial = ((SQ_W+2)'(root_prev) << (K + 1)) + ((SQ_W+2)'(1) << (2 * K));
         if ((SQ_W+2)'(rem_prev) >= trial) begin
            rem_in  = SQ_W'((SQ_W+2)'(rem_prev) - trial);
            root_in = root_prev | (ROOT_W'(1) << K);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (ctl_in.advance) begin
            v_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl_in.advance) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
         end
      end
   end

   // Round up when the remainder exceeds the floor root.
   assign rnd_in = (rem_ff[ROOT_W-1] > SQ_W'(root_ff[ROOT_W-1]))
                 ? root_ff[ROOT_W-1] + ROOT_W'(1) : root_ff[ROOT_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
      end else if (ctl_in.advance) begin
         vr_ff <= v_ff[ROOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.advance) begin
         rnd_ff <= rnd_in;
      end
   end

   assign out_valid = vr_ff;
   assign root      = rnd_ff;

endmodule

`default_nettype wire

>>> rtl/core/equirectangular_distance.sv
// ----------------------------------------------------------------------------
// equirectangular_distance
// Approximate distance in millimetres between two positions given in
// 1e-7 degree, by the equirectangular projection on a sphere.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel takes one word holding two positions (latitude and
//   longitude of each). The rsp_ channel returns one word per request: the
//   distance in millimetres, rounded, saturated at 45000000000.
//   The csr_ channel writes the sphere radius in metres; it is always ready
//   and should be written only while no request is in flight.
//   The pipeline holds five stages of angle conversion, a reduction stage,
//   one stage per CORDIC step, the cosine, product, rounding, squares and
//   sum stages, one stage per root bit of the 32-bit square root with a
//   rounding stage, the scaling stages and the output register.
//   Throughput is one word per cycle while responses are taken. When the
//   receiver stalls, the finished word waits in the output register while
//   the pipeline keeps taking requests until the next result reaches its
//   last stage; then the whole pipeline holds and req_ready drops.
//   Reset clears all valid bits and loads the radius with 6372797 m.
// ----------------------------------------------------------------------------
`default_nettype none

module equirectangular_distance #(
   parameter int CORDIC_STEPS = 30
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [edist_pkg::LAT_W-1:0]   req_lat_a,
   input  logic signed [edist_pkg::LON_W-1:0]   req_lon_a,
   input  logic signed [edist_pkg::LAT_W-1:0]   req_lat_b,
   input  logic signed [edist_pkg::LON_W-1:0]   req_lon_b,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [edist_pkg::DIST_W-1:0]         rsp_distance_mm,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [edist_pkg::RADIUS_W-1:0]       csr_earth_radius_m
);
   import edist_pkg::*;

   logic                 advance;
   pipe_ctl_type         ctl_in, ctl_p, ctl_s;
   logic [RADIUS_W-1:0]  radius_ff;

   logic signed [31:0]   lat_sum;
   logic                 rad_valid;
   logic signed [RAD_W-1:0] rad_la, rad_oa, rad_lb, rad_ob, rad_mean;

   // Reduction stage.
   logic                 p_v_ff;
   logic [29:0]          m_abs, m_red;
   logic signed [ZW-1:0] p_z_ff, p_z_in;
   logic                 p_neg_ff, p_neg_in;
   logic signed [DIFF_W-1:0] p_dy_ff, p_dy_in, p_dl_ff, p_dl_in;

   // CORDIC results.
   logic                   cr_valid, cr_neg;
   logic signed [CS_W-1:0] cr_x;
   logic [2*DIFF_W-1:0]    cr_side;

   // Cosine, product, rounding, squares and sum stages.
   logic                     c1_v_ff, c2_v_ff, c3_v_ff, c4_v_ff, c5_v_ff;
   logic signed [CS_W-1:0]   x_clamp;
   logic signed [COS_W-1:0]  c1_cos_ff, c1_cos_in;
   logic signed [DIFF_W-1:0] c1_dy_ff, c1_dl_ff, c2_dy_ff;
   logic signed [63:0]       c2_prod_ff, c2_prod_in;
   logic [63:0]              prod_mag;
   logic [63:0]              prod_rnd;
   logic [31:0]              c3_dx_ff, c3_dx_in, c3_dy_ff, c3_dy_in;
   logic [SQ_W-1:0]          c4_dx2_ff, c4_dy2_ff, c5_sum_ff;

   // Square root and scaling.
   logic                 sq_valid;
   logic [ROOT_W-1:0]    sq_root;
   logic                 r1_v_ff, sc_v_ff;
   logic [54:0]          r1_p_ff, r1_p_in;
   logic [61:0]          scaled;
   logic [36:0]          mm;
   logic [DIST_W-1:0]    sc_ff, sc_in;

   // Output register.
   logic                 out_v_ff;
   logic [DIST_W-1:0]    out_ff;
   logic                 out_load;

   // Flow control: the pipeline moves unless a result waits at its end
   // while the output register is full and not taken.
   assign out_load  = sc_v_ff && (!out_v_ff || rsp_ready);
   assign advance   = !sc_v_ff || out_load;
   assign req_ready = advance;
   assign ctl_in    = '{advance: advance, valid: req_valid};
   assign ctl_p     = '{advance: advance, valid: p_v_ff};
   assign ctl_s     = '{advance: advance, valid: c5_v_ff};

   // Radius register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid) begin
         radius_ff <= csr_earth_radius_m;
      end
   end

   // Angle conversion of the four coordinates and of the latitude sum.
   assign lat_sum = $signed({req_lat_a[LAT_W-1], req_lat_a})
                  + $signed({req_lat_b[LAT_W-1], req_lat_b});

   edist_to_rad u_rad_la (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl_in),
      .wide      (1'b0),
      .value     ($signed({req_lat_a[LAT_W-1], req_lat_a})),
      .out_valid (rad_valid),
      .rad       (rad_la)
   );

   edist_to_rad u_rad_oa (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl_in),
      .wide      (1'b0),
      .value     (req_lon_a),
      .out_valid (),
      .rad       (rad_oa)
   );

   edist_to_rad u_rad_lb (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl_in),
      .wide      (1'b0),
      .value     ($signed({req_lat_b[LAT_W-1], req_lat_b})),
      .out_valid (),
      .rad       (rad_lb)
   );

   edist_to_rad u_rad_ob (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl_in),
      .wide      (1'b0),
      .value     (req_lon_b),
      .out_valid (),
      .rad       (rad_ob)
   );

   edist_to_rad u_rad_mean (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl_in),
      .wide      (1'b1),
      .value     (lat_sum),
      .out_valid (),
      .rad       (rad_mean)
   );

   // Differences, and folding of the mean latitude into the first quadrant.
   always_comb begin
      m_abs    = rad_mean[RAD_W-1] ? 30'(-rad_mean) : 30'(rad_mean);
      p_neg_in = (m_abs > HALF_PI_Q28);
      m_red    = p_neg_in ? (PI_Q28 - m_abs) : m_abs;
      p_z_in   = $signed({1'b0, m_red, 2'b00});
      p_dy_in  = $signed({rad_lb[RAD_W-1], rad_lb}) - $signed({rad_la[RAD_W-1], rad_la});
      p_dl_in  = $signed({rad_ob[RAD_W-1], rad_ob}) - $signed({rad_oa[RAD_W-1], rad_oa});
   end

   edist_cordic #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W (2 * DIFF_W)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl_p),
      .z_in      (p_z_ff),
      .neg_in    (p_neg_ff),
      .side_in   ({p_dy_ff, p_dl_ff}),
      .out_valid (cr_valid),
      .x_out     (cr_x),
      .neg_out   (cr_neg),
      .side_out  (cr_side)
   );

   // Cosine: clamp to one and apply the quadrant sign.
   always_comb begin
      x_clamp   = (cr_x > ONE_Q30) ? ONE_Q30 : cr_x;
      c1_cos_in = cr_neg ? COS_W'(-x_clamp) : COS_W'(x_clamp);
   end

   // Longitude difference scaled by the cosine.
   assign c2_prod_in = 64'(c1_dl_ff) * 64'(c1_cos_ff);

   // Magnitudes, with the product rounded half away from zero.
   always_comb begin
      prod_mag = c2_prod_ff[63] ? (~c2_prod_ff + 64'd1) : c2_prod_ff;
      prod_rnd = prod_mag + (64'd1 << 29);
      c3_dx_in = 32'(prod_rnd >> 30);
      c3_dy_in = c2_dy_ff[DIFF_W-1] ? (~c2_dy_ff + 32'd1) : c2_dy_ff;
   end

   // Valid bits of the middle stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff  <= 1'b0;
         c1_v_ff <= 1'b0;
         c2_v_ff <= 1'b0;
         c3_v_ff <= 1'b0;
         c4_v_ff <= 1'b0;
         c5_v_ff <= 1'b0;
         r1_v_ff <= 1'b0;
         sc_v_ff <= 1'b0;
      end else if (advance) begin
         p_v_ff  <= rad_valid;
         c1_v_ff <= cr_valid;
         c2_v_ff <= c1_v_ff;
         c3_v_ff <= c2_v_ff;
         c4_v_ff <= c3_v_ff;
         c5_v_ff <= c4_v_ff;
         r1_v_ff <= sq_valid;
         sc_v_ff <= r1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_z_ff     <= p_z_in;
         p_neg_ff   <= p_neg_in;
         p_dy_ff    <= p_dy_in;
         p_dl_ff    <= p_dl_in;
         c1_cos_ff  <= c1_cos_in;
         c1_dy_ff   <= cr_side[2*DIFF_W-1:DIFF_W];
         c1_dl_ff   <= cr_side[DIFF_W-1:0];
         c2_prod_ff <= c2_prod_in;
         c2_dy_ff   <= c1_dy_ff;
         c3_dx_ff   <= c3_dx_in;
         c3_dy_ff   <= c3_dy_in;
         c4_dx2_ff  <= 64'(c3_dx_ff) * 64'(c3_dx_ff);
         c4_dy2_ff  <= 64'(c3_dy_ff) * 64'(c3_dy_ff);
         c5_sum_ff  <= c4_dx2_ff + c4_dy2_ff;
         r1_p_ff    <= r1_p_in;
         sc_ff      <= sc_in;
      end
   end

   edist_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl_s),
      .radicand  (c5_sum_ff),
      .out_valid (sq_valid),
      .root      (sq_root)
   );

   // Angular distance times radius, then to millimetres with saturation.
   assign r1_p_in = 55'(sq_root) * 55'(radius_ff);

   always_comb begin
      scaled = 62'(r1_p_ff) * 62'(7'd125) + (62'd1 << 24);
      mm     = 37'(scaled >> 25);
      sc_in  = (mm > 37'(DIST_MAX)) ? DIST_MAX : DIST_W'(mm);
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_load) begin
         out_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= sc_ff;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_distance_mm = out_ff;

endmodule

`default_nettype wire
